/* rtl/core/ffba_pkg.sv */
`default_nettype none

package ffba_pkg;

	localparam int BLOCK_COUNT = 1024;
	localparam int MAX_RUN     = 64;

	localparam int IDX_W   = $clog2(BLOCK_COUNT);
	localparam int CNT_W   = $clog2(BLOCK_COUNT + 1);
	localparam int BLK_W   = 10;
	localparam int NREQ_W  = 7;
	localparam int RUN_W   = $clog2(MAX_RUN + 1);
	localparam int CMP_W   = (CNT_W > NREQ_W) ? CNT_W : NREQ_W;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_COUNT - 1);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_ALLOC
	} state_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [BLK_W-1:0] wr_data;
		logic [IDX_W-1:0] rd_addr;
	} store_req_t;

	typedef struct packed {
		logic             valid;
		logic [BLK_W-1:0] blk;
		status_t          status;
		logic             last;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/ffba_store.sv */
`default_nettype none

module ffba_store
	import ffba_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  store_req_t       req,
	output logic [BLK_W-1:0] rd_data
);

	logic [BLK_W-1:0] mem [BLOCK_COUNT];
	logic [BLK_W-1:0] mem_s1;
	logic [BLK_W-1:0] dflt_s1;
	logic             use_mem_s1;
	logic [CNT_W-1:0] fill_q;
	logic             written;
	logic [BLK_W-1:0] dflt;

	// entries are written in order from the last slot, then 0 upward
	always_comb begin
		written = (fill_q == CNT_W'(BLOCK_COUNT)) ||
			((fill_q != '0) && ((req.rd_addr == LAST_IDX) ||
			(({1'b0, req.rd_addr} + CNT_W'(1)) < fill_q)));
		if (req.rd_addr == LAST_IDX) begin
			dflt = '0;
		end else begin
			dflt = BLK_W'({1'b0, req.rd_addr} + CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		mem_s1 <= mem[req.rd_addr];
	end

	always_ff @(posedge clk) begin
		dflt_s1 <= dflt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			use_mem_s1 <= 1'b0;
		end else begin
			use_mem_s1 <= written;
			if (req.wr_en && (fill_q != CNT_W'(BLOCK_COUNT))) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	assign rd_data = use_mem_s1 ? mem_s1 : dflt_s1;

endmodule

`default_nettype wire

/* rtl/core/ffba_ctrl.sv */
`default_nettype none

module ffba_ctrl
	import ffba_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               func,
	input  wire  [NREQ_W-1:0] alloc_count,
	input  wire  [BLK_W-1:0]  freed_block,
	input  wire               out_free,
	input  wire  [BLK_W-1:0]  rd_data,
	output store_req_t        req,
	output result_t           res
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [RUN_W-1:0] rem_q, rem_d;
	logic             accept;
	logic [IDX_W-1:0] head_nx;
	logic [IDX_W-1:0] tail_nx;

	always_comb begin
		head_nx = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
		tail_nx = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		rem_d       = rem_q;
		in_ready    = 1'b0;
		accept      = 1'b0;
		req.wr_en   = 1'b0;
		req.wr_addr = tail_q;
		req.wr_data = freed_block;
		req.rd_addr = head_q;
		res.valid   = 1'b0;
		res.blk     = '0;
		res.status  = STAT_OK;
		res.last    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				accept   = in_valid && out_free;
				if (accept) begin
					res.valid = 1'b1;
					if (func == FUNC_FREE) begin
						if (count_q == CNT_W'(BLOCK_COUNT)) begin
							res.status = STAT_FULL;
						end else begin
							req.wr_en = 1'b1;
							tail_d    = tail_nx;
							count_d   = count_q + CNT_W'(1);
						end
					end else if (alloc_count == '0) begin
						res.status = STAT_OK;
					end else if ((alloc_count > NREQ_W'(MAX_RUN)) ||
						(CMP_W'(alloc_count) > CMP_W'(count_q))) begin
						res.status = STAT_SHORT;
					end else begin
						res.valid = 1'b0;
						rem_d     = RUN_W'(alloc_count);
						state_d   = ST_ALLOC;
					end
				end
			end
			ST_ALLOC: begin
				if (out_free) begin
					res.valid   = 1'b1;
					res.blk     = rd_data;
					res.last    = (rem_q == RUN_W'(1));
					req.rd_addr = head_nx;
					head_d      = head_nx;
					count_d     = count_q - CNT_W'(1);
					rem_d       = rem_q - RUN_W'(1);
					if (rem_q == RUN_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= LAST_IDX;
			count_q <= CNT_W'(BLOCK_COUNT - 1);
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			rem_q   <= rem_d;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BLOCK_COUNT))
		else $error("free count beyond store depth");

	a_run_covered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC) |-> ((rem_q != '0) && (CNT_W'(rem_q) <= count_q)))
		else $error("run longer than free list");

	a_free_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FUNC_FREE) && (count_q != CNT_W'(BLOCK_COUNT)))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("free transaction not counted");

	a_run_advances: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ALLOC) && out_free) |=> (head_q != $past(head_q)))
		else $error("head held on a granted block");
`endif

endmodule

`default_nettype wire

/* rtl/core/fifo_free_block_allocator_unit.sv */
`default_nettype none

// channel  dir  tdata (low bit up)                       tuser        tlast
// s_*      in   alloc_count[6:0], freed_block[16:7]      func         -
// m_*      out  granted_block[9:0]                       status[1:0]  last_of_run
//
// Free, failure and empty requests: accepted from idle, one transaction out.
// Allocate of n blocks: accepted with no output, then one block per cycle from the
// store's single read port while the output is free; no input until the run ends.
// No clearing pass after reset: a write watermark serves unwritten entries.
// A low m_tready holds the result register and stops the run; s_tready drops.

module fifo_free_block_allocator_unit
	import ffba_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // alloc_count[6:0], freed_block[16:7]
	input  wire  [0:0]  s_tuser,   // func[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // granted_block[9:0]
	output logic [1:0]  m_tuser,   // status[1:0]
	output logic        m_tlast
);

	store_req_t       req;
	result_t          res;
	logic [BLK_W-1:0] rd_data;
	logic             out_free;
	logic             m_tvalid_q;
	logic [BLK_W-1:0] blk_q;
	status_t          status_q;
	logic             last_q;

	assign out_free = !m_tvalid_q || m_tready;

	ffba_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	ffba_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.func        (s_tuser[0]),
		.alloc_count (s_tdata[6:0]),
		.freed_block (s_tdata[16:7]),
		.out_free    (out_free),
		.rd_data     (rd_data),
		.req         (req),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			blk_q    <= res.blk;
			status_q <= res.status;
			last_q   <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - BLK_W){1'b0}}, blk_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire
